/* hdl/buddy_block_allocator_defines.svh */
// Assertion macros shared by the allocator RTL.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bba_pkg.sv */
// Shared types, codes and constants of the buddy block allocator.
`timescale 1ns / 1ps
package bba_pkg;

  // Fixed field widths
  localparam int DATA_W     = 32;
  localparam int UNIT_W     = 17;
  localparam int OFF_W      = 26;
  localparam int STATUS_W   = 2;

  // Defaults
  localparam int NUM_BLOCKS_DEF = 1024;
  localparam logic [UNIT_W-1:0] UNIT_RESET = 17'd4096;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_BADADDR  = 2'd2,
    ST_NOTALLOC = 2'd3
  } bba_status_t;

  // Divider result bundle
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
    logic [UNIT_W-1:0] rem;
  } bba_div_res_t;

  // Largest power of two not above v (elaboration only)
  function automatic int pow2_floor(input int v);
    int p;
    p = 1;
    while (p <= (v >> 1))
      p = p * 2;
    return p;
  endfunction

endpackage

/* hdl/bba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/bba_div.sv */
// Radix-2 restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module bba_div
  import bba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [UNIT_W-1:0] divisor,
  output bba_div_res_t      res
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [UNIT_W-1:0] rem_r, rem_nxt;
  logic [UNIT_W-1:0] dvs_r;
  logic [UNIT_W:0]   trial;
  logic [UNIT_W:0]   diff;
  logic              fits;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, quo_r[DATA_W-1]};
    diff    = trial - {1'b0, dvs_r};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[UNIT_W-1:0] : trial[UNIT_W-1:0];
    quo_nxt = {quo_r[DATA_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

/* hdl/buddy_block_allocator.sv */
// Buddy block allocator top level: sequencer, node tree RAM and divider.
//
//   channel  | ports                                      | dir
//   ---------+--------------------------------------------+-----
//   input    | in_valid/in_ready, in_cmd, in_req_bytes,   | in
//            | in_free_offset                             |
//   result   | out_valid/out_ready, out_status,           | out
//            | out_byte_offset                            |
//   config   | cfg_we, cfg_wdata (unit size)              | in
//
// One beat at a time. The divider holds the sequencer until it is done; each
// tree level walked costs a read and a compare state on the single RAM read
// port. An alloc walks down from the root to the granted node and back up to
// the root, a free walks up from its leaf to the granted node and on to the
// root; refused requests end sooner. After reset a clearing pass writes every
// tree node; in_ready stays low during it. A stalled result holds in the output
// registers and the next beat is taken once it leaves.
`timescale 1ns / 1ps
`include "buddy_block_allocator_defines.svh"
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [UNIT_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [DATA_W-1:0]   in_req_bytes,
  input  logic [DATA_W-1:0]   in_free_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [OFF_W-1:0]    out_byte_offset
);

  localparam int LEAVES = pow2_floor(NUM_BLOCKS);
  localparam int LEVELS = $clog2(LEAVES);
  localparam int DEPTH  = 2 * LEAVES - 1;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int NODE_W = LEVELS + 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_ACHK, S_ROOT, S_DRD, S_DCMP, S_FCHK,
    S_URD, S_UCMP, S_MARK, S_ARD, S_ACMP, S_FIN, S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic               cmd_r, cmd_nxt;
  logic [UNIT_W-1:0]  unit_r;
  logic [UNIT_W-1:0]  unit_eff;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [NODE_W-1:0]  nodes_r, nodes_nxt;
  logic [NODE_W-1:0]  need_r, need_nxt;
  logic [LEVELS-1:0]  blk_r, blk_nxt;
  logic [NODE_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [NODE_W:0]    span_r, span_nxt;
  bba_status_t        status_r, status_nxt;
  logic [OFF_W-1:0]   offset_r, offset_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [NODE_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [NODE_W-1:0]  ram_rdata;

  logic               div_start;
  logic [DATA_W-1:0]  div_dividend;
  bba_div_res_t       div_res;

  logic [DATA_W:0]    want;
  logic [DATA_W:0]    want_eff;
  logic [LEVELS-1:0]  smear;
  logic [NODE_W-1:0]  need_calc;
  logic [IDX_W-1:0]   left_idx;
  logic [IDX_W-1:0]   par_idx;
  logic [IDX_W-1:0]   sib_idx;
  logic [IDX_W-1:0]   leaf_idx;
  logic [NODE_W-1:0]  half;
  logic [NODE_W-1:0]  pnodes;
  logic [NODE_W:0]    pair_sum;
  logic [NODE_W-1:0]  merge_val;
  logic [NODE_W:0]    span_use;
  logic [OFF_W-1:0]   prod;
  logic               accept;

  assign unit_eff = (unit_r == '0) ? UNIT_W'(1) : unit_r;
  assign accept   = in_valid && in_ready;

  // Shared divider: request or offset over the unit size
  assign div_start    = accept;
  assign div_dividend = (in_cmd == CMD_ALLOC) ? in_req_bytes : in_free_offset;

  bba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (unit_eff),
    .res      (div_res)
  );

  // Free-run tree, one node per entry
  bba_ram #(
    .WIDTH (NODE_W),
    .DEPTH (DEPTH)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request in blocks, rounded up; then up to a power of two
  always_comb begin
    want     = {1'b0, div_res.quo} + {{DATA_W{1'b0}}, (div_res.rem != '0)};
    want_eff = (want == '0) ? (DATA_W+1)'(1) : want;
    smear    = LEVELS'(want_eff - 1'b1);
    for (int k = 1; k < LEVELS; k = k * 2) begin
      smear = smear | (smear >> k);
    end
    need_calc = {1'b0, smear} + 1'b1;
  end

  // Tree index arithmetic
  assign left_idx = {idx_r[IDX_W-2:0], 1'b1};
  assign par_idx  = (idx_r - 1'b1) >> 1;
  assign sib_idx  = idx_r[0] ? (idx_r + 1'b1) : (idx_r - 1'b1);
  assign leaf_idx = IDX_W'(div_res.quo[LEVELS-1:0]) + IDX_W'(LEAVES - 1);
  assign half     = nodes_r >> 1;
  assign pnodes   = nodes_r << 1;

  // Parent value: whole if both halves are wholly free, else the larger run
  assign pair_sum  = {1'b0, cur_r} + {1'b0, ram_rdata};
  assign merge_val = (pair_sum == {1'b0, pnodes}) ? pnodes :
                     ((cur_r > ram_rdata) ? cur_r : ram_rdata);

  // Clearing pass: span halves at the first node of each level
  assign span_use = (((clr_idx_r + 1'b1) & clr_idx_r) == '0) ? (span_r >> 1) : span_r;

  // Byte offset of the granted block
  assign prod = OFF_W'(blk_r) * OFF_W'(unit_eff);

  // Sequencer next state
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    idx_nxt     = idx_r;
    nodes_nxt   = nodes_r;
    need_nxt    = need_r;
    blk_nxt     = blk_r;
    cur_nxt     = cur_r;
    clr_idx_nxt = clr_idx_r;
    span_nxt    = span_r;
    status_nxt  = status_r;
    offset_nxt  = offset_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = cur_r;
    ram_raddr   = '0;

    case (state_r)
      S_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wdata   = span_use[NODE_W-1:0];
        span_nxt    = span_use;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_cmd;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          state_nxt = (cmd_r == CMD_ALLOC) ? S_ACHK : S_FCHK;
        end
      end
      S_ACHK: begin
        offset_nxt = '0;
        if (want_eff > (DATA_W+1)'(LEAVES)) begin
          status_nxt = ST_NOSPACE;
          state_nxt  = S_OUT;
        end else begin
          need_nxt  = need_calc;
          nodes_nxt = NODE_W'(LEAVES);
          idx_nxt   = '0;
          blk_nxt   = '0;
          ram_raddr = '0;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (ram_rdata < need_r) begin
          status_nxt = ST_NOSPACE;
          state_nxt  = S_OUT;
        end else if (nodes_r > need_r) begin
          state_nxt = S_DRD;
        end else begin
          state_nxt = S_MARK;
        end
      end
      S_DRD: begin
        ram_raddr = left_idx;
        state_nxt = S_DCMP;
      end
      S_DCMP: begin
        // Left child first; else take the right one
        if (ram_rdata >= need_r) begin
          idx_nxt = left_idx;
        end else begin
          idx_nxt = left_idx + 1'b1;
          blk_nxt = blk_r + half[LEVELS-1:0];
        end
        nodes_nxt = half;
        state_nxt = (half > need_r) ? S_DRD : S_MARK;
      end
      S_FCHK: begin
        offset_nxt = '0;
        if ((div_res.rem != '0) || (div_res.quo >= DATA_W'(LEAVES))) begin
          status_nxt = ST_BADADDR;
          state_nxt  = S_OUT;
        end else begin
          idx_nxt   = leaf_idx;
          nodes_nxt = NODE_W'(1);
          state_nxt = S_URD;
        end
      end
      S_URD: begin
        ram_raddr = idx_r;
        state_nxt = S_UCMP;
      end
      S_UCMP: begin
        // Walk up until the granted node (value zero)
        if (ram_rdata == '0) begin
          state_nxt = S_MARK;
        end else if (idx_r == '0) begin
          status_nxt = ST_NOTALLOC;
          state_nxt  = S_OUT;
        end else begin
          idx_nxt   = par_idx;
          nodes_nxt = pnodes;
          state_nxt = S_URD;
        end
      end
      S_MARK: begin
        cur_nxt   = (cmd_r == CMD_ALLOC) ? '0 : nodes_r;
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = cur_nxt;
        state_nxt = (idx_r == '0) ? S_FIN : S_ARD;
      end
      S_ARD: begin
        ram_raddr = sib_idx;
        state_nxt = S_ACMP;
      end
      S_ACMP: begin
        ram_we    = 1'b1;
        ram_waddr = par_idx;
        ram_wdata = merge_val;
        cur_nxt   = merge_val;
        idx_nxt   = par_idx;
        nodes_nxt = pnodes;
        state_nxt = (par_idx == '0) ? S_FIN : S_ARD;
      end
      S_FIN: begin
        status_nxt = ST_OK;
        offset_nxt = (cmd_r == CMD_ALLOC) ? prod : '0;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_idx_r <= '0;
      span_r    <= (NODE_W+1)'(2 * LEAVES);
      unit_r    <= UNIT_RESET;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      span_r    <= span_nxt;
      if (cfg_we) begin
        unit_r <= cfg_wdata;
      end
    end
    cmd_r    <= cmd_nxt;
    idx_r    <= idx_nxt;
    nodes_r  <= nodes_nxt;
    need_r   <= need_nxt;
    blk_r    <= blk_nxt;
    cur_r    <= cur_nxt;
    status_r <= status_nxt;
    offset_r <= offset_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_status      = status_r;
  assign out_byte_offset = offset_r;

  // Checks
  `BBA_ASSERT_NOW(a_one_in_flight, out_valid, !in_ready, "ready while a result waits")
  `BBA_ASSERT_NOW(a_offset_zero, out_valid && (out_status != ST_OK) && 1'b1, out_byte_offset == '0, "nonzero offset on failure")
  `BBA_ASSERT_NOW(a_no_idle_write, state_r == S_IDLE || state_r == S_OUT, !ram_we, "tree written while idle")
  `BBA_ASSERT_NEXT(a_accept_divides, accept, state_r == S_DIV, "beat taken without divide")

endmodule

/* tb/bba_checker.sv */
// Result checker for the buddy block allocator: mirrors the tree and compares every result beat.
`timescale 1ns / 1ps
module bba_checker
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [UNIT_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_cmd,
  input  logic [DATA_W-1:0]   in_req_bytes,
  input  logic [DATA_W-1:0]   in_free_offset,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [OFF_W-1:0]    out_byte_offset,
  output int unsigned         mismatches,
  output int unsigned         outstanding
);

  localparam int NODE_W = $clog2(NUM_BLOCKS) + 1;
  localparam int TREE_N = 2 * NUM_BLOCKS - 1;

  typedef struct packed {
    bba_status_t       status;
    logic [OFF_W-1:0]  offset;
  } grant_t;

  // Mirror of the free-run tree, heap order
  logic [NODE_W-1:0] free_run [TREE_N];
  logic [UNIT_W-1:0] unit_bytes;
  int unsigned       leaf_cnt;
  grant_t            grant_q[$];
  int unsigned       beat_no;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    beat_no     = 0;
    unit_bytes  = UNIT_RESET;
  end

  // Every node starts out holding the block count of its subtree
  task automatic clear_tree();
    int unsigned span;
    leaf_cnt = 1;
    while (leaf_cnt * 2 <= NUM_BLOCKS)
      leaf_cnt = leaf_cnt * 2;
    span = leaf_cnt * 2;
    for (int i = 0; i < TREE_N; i++) begin
      if (i < 2 * leaf_cnt - 1) begin
        if (((i + 1) & i) == 0)
          span = span / 2;
        free_run[i] = NODE_W'(span);
      end else begin
        free_run[i] = '0;
      end
    end
  endtask

  function automatic longint unsigned eff_unit();
    return (unit_bytes == '0) ? 64'd1 : {47'd0, unit_bytes};
  endfunction

  // Grant: round up to a power-of-two block count, descend left-first, refresh ancestors
  function automatic grant_t carve_block(input logic [DATA_W-1:0] req);
    grant_t            g;
    longint unsigned   unit, want, blk;
    logic [63:0]       prod;
    int unsigned       need, span, idx, l, r;
    g.status = ST_OK;
    g.offset = '0;
    unit = eff_unit();
    want = ({32'd0, req} + unit - 1) / unit;
    if (want == 0)
      want = 1;
    if (want > leaf_cnt) begin
      g.status = ST_NOSPACE;
      return g;
    end
    need = 1;
    while (need < want)
      need = need * 2;
    if (free_run[0] < need) begin
      g.status = ST_NOSPACE;
      return g;
    end
    idx = 0;
    for (span = leaf_cnt; span > need; span = span / 2)
      idx = (free_run[2 * idx + 1] >= need) ? 2 * idx + 1 : 2 * idx + 2;
    free_run[idx] = '0;
    blk = (idx + 1) * span - leaf_cnt;
    while (idx != 0) begin
      idx = (idx - 1) / 2;
      l = free_run[2 * idx + 1];
      r = free_run[2 * idx + 2];
      free_run[idx] = NODE_W'((l > r) ? l : r);
    end
    prod = blk * unit;
    g.offset = prod[OFF_W-1:0];
    return g;
  endfunction

  // Release: walk up to the granted node, mark it free, merge fully free buddies
  function automatic grant_t release_block(input logic [DATA_W-1:0] off);
    grant_t            g;
    longint unsigned   unit, blk, off64;
    int unsigned       span, idx, l, r;
    g.status = ST_OK;
    g.offset = '0;
    unit  = eff_unit();
    off64 = {32'd0, off};
    blk   = off64 / unit;
    if (blk * unit != off64 || blk >= leaf_cnt) begin
      g.status = ST_BADADDR;
      return g;
    end
    idx  = 32'(blk) + leaf_cnt - 1;
    span = 1;
    while (free_run[idx] != 0) begin
      if (idx == 0) begin
        g.status = ST_NOTALLOC;
        return g;
      end
      idx  = (idx - 1) / 2;
      span = span * 2;
    end
    free_run[idx] = NODE_W'(span);
    while (idx != 0) begin
      idx  = (idx - 1) / 2;
      span = span * 2;
      l = free_run[2 * idx + 1];
      r = free_run[2 * idx + 2];
      free_run[idx] = NODE_W'((l + r == span) ? span : ((l > r) ? l : r));
    end
    return g;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                 input longint unsigned got_v);
    $display("[%0t] result beat %0d: %s expected 0x%0h, got 0x%0h",
             $time, beat_no, what, exp_v, got_v);
    mismatches++;
  endtask

  // Sample both channels at the rising edge; pop before push
  always @(posedge clk) begin : watch
    grant_t exp_g;
    if (!rst_n) begin
      clear_tree();
      unit_bytes = UNIT_RESET;
      grant_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we)
        unit_bytes = cfg_wdata;
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          report_mismatch("unexpected beat, status", 0, out_status);
        end else begin
          exp_g = grant_q.pop_front();
          if (out_status !== exp_g.status)
            report_mismatch("status", exp_g.status, out_status);
          if (out_byte_offset !== exp_g.offset)
            report_mismatch("byte_offset", exp_g.offset, out_byte_offset);
        end
        beat_no++;
      end
      if (in_valid && in_ready) begin
        if (in_cmd == CMD_ALLOC)
          grant_q.push_back(carve_block(in_req_bytes));
        else
          grant_q.push_back(release_block(in_free_offset));
      end
      outstanding <= grant_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for the buddy block allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import bba_pkg::*;

  localparam int          NUM_BLOCKS  = NUM_BLOCKS_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [63:0] OFF_MASK    = (64'd1 << OFF_W) - 1;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [UNIT_W-1:0]   cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                in_cmd;
  logic [DATA_W-1:0]   in_req_bytes;
  logic [DATA_W-1:0]   in_free_offset;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [OFF_W-1:0]    out_byte_offset;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_cnt;
  int unsigned unit_now;      // effective unit, zero counts as one
  logic        quiet_tail;    // no idling on either side
  int unsigned stall_left;
  int unsigned calm_left;
  logic        sent_cmd_q[$];
  int unsigned live_blk[$];   // block numbers believed granted

  buddy_block_allocator #(.NUM_BLOCKS(NUM_BLOCKS)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_req_bytes(in_req_bytes), .in_free_offset(in_free_offset),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_byte_offset(out_byte_offset)
  );

  bba_checker #(.NUM_BLOCKS(NUM_BLOCKS)) checker_i (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_req_bytes(in_req_bytes), .in_free_offset(in_free_offset),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_byte_offset(out_byte_offset), .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, calm stretches, none in the tail
  always @(negedge clk) begin
    if (!rst_n || quiet_tail) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm_left != 0) begin
      out_ready <= 1'b1;
      calm_left <= calm_left - 1;
    end else if ($urandom_range(0, 49) == 0) begin
      out_ready <= 1'b1;
      calm_left <= $urandom_range(30, 80);
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Map a granted offset back to its block number
  function automatic int unsigned block_of(input logic [OFF_W-1:0] off);
    logic [63:0] prod;
    if (unit_now <= 65536)
      return off / unit_now;
    for (int unsigned b = 0; b < NUM_BLOCKS; b++) begin
      prod = b * 64'(unit_now);
      if ((prod & OFF_MASK) == {38'd0, off})
        return b;
    end
    return 0;
  endfunction

  // Track grants so that frees can target live blocks
  always @(posedge clk) begin : grant_track
    logic cmd;
    if (rst_n && out_valid && out_ready && sent_cmd_q.size() != 0) begin
      cmd = sent_cmd_q.pop_front();
      if (cmd == CMD_ALLOC && out_status == ST_OK)
        live_blk.push_back(block_of(out_byte_offset));
    end
  end

  task automatic send_beat(input logic cmd, input logic [DATA_W-1:0] req,
                           input logic [DATA_W-1:0] off);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_req_bytes   <= req;
    in_free_offset <= off;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    sent_cmd_q.push_back(cmd);
  endtask

  task automatic hold_off(input int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Pause the sender until every result beat is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || sent_cmd_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_unit(input logic [UNIT_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    unit_now  = (v == '0) ? 1 : v;
  endtask

  function automatic logic [DATA_W-1:0] units_to_bytes(input longint unsigned n);
    logic [63:0] b;
    b = n * unit_now;
    return b[DATA_W-1:0];
  endfunction

  // Random traffic; gaps selects sender idling
  task automatic run_random(input int unsigned n, input logic gaps);
    int unsigned     pick, units, idx, blk;
    logic            cmd, calm;
    logic [DATA_W-1:0] req, off;
    calm = 1'b0;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 30 == 0)
        calm = ($urandom_range(0, 3) == 0);
      req = $urandom;
      off = $urandom;
      if (live_blk.size() == 0)
        cmd = ($urandom_range(0, 4) == 0) ? CMD_FREE : CMD_ALLOC;
      else if (live_blk.size() > 40)
        cmd = ($urandom_range(0, 9) < 7) ? CMD_FREE : CMD_ALLOC;
      else
        cmd = ($urandom_range(0, 1) == 0) ? CMD_FREE : CMD_ALLOC;
      pick = $urandom_range(0, 99);
      if (cmd == CMD_ALLOC) begin
        if (pick < 8) begin
          req = '0;
        end else if (pick < 16) begin
          req = $urandom;
        end else if (pick < 28) begin
          units = $urandom_range(1, NUM_BLOCKS + 1);
          req = units_to_bytes(units) + $urandom_range(0, 2) - 1;
        end else begin
          units = 1 << $urandom_range(0, 6);
          req = units_to_bytes(units) - $urandom_range(0, unit_now - 1);
        end
      end else begin
        if (pick < 65 && live_blk.size() != 0) begin
          idx = $urandom_range(0, live_blk.size() - 1);
          blk = live_blk[idx];
          // now and then keep it listed to provoke a double free
          if ($urandom_range(0, 9) != 0)
            live_blk.delete(idx);
          // interior offset releases the whole enclosing block
          if ($urandom_range(0, 7) == 0)
            blk = blk + 1;
          off = units_to_bytes(blk);
        end else if (pick < 75 && unit_now > 1) begin
          off = units_to_bytes($urandom_range(0, NUM_BLOCKS - 1))
                + $urandom_range(1, unit_now - 1);
        end else if (pick < 85) begin
          off = units_to_bytes(NUM_BLOCKS + $urandom_range(0, 3));
        end else if (pick < 93) begin
          off = units_to_bytes($urandom_range(0, NUM_BLOCKS - 1));
        end
      end
      send_beat(cmd, req, off);
      if (gaps && !calm && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 6));
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_cmd         = CMD_ALLOC;
    in_req_bytes   = '0;
    in_free_offset = '0;
    out_ready      = 1'b0;
    quiet_tail     = 1'b0;
    stall_left     = 0;
    calm_left      = 0;
    cycle_cnt      = 0;
    unit_now       = UNIT_RESET;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: rounding, zero size, oversize, bad and stray frees, merging
    send_beat(CMD_ALLOC, 0, $urandom);
    send_beat(CMD_ALLOC, 1, $urandom);
    send_beat(CMD_ALLOC, units_to_bytes(1), $urandom);
    send_beat(CMD_ALLOC, units_to_bytes(1) + 1, $urandom);
    send_beat(CMD_ALLOC, 32'hFFFF_FFFF, $urandom);
    send_beat(CMD_ALLOC, units_to_bytes(NUM_BLOCKS), $urandom);
    send_beat(CMD_FREE, $urandom, 1);
    send_beat(CMD_FREE, $urandom, units_to_bytes(NUM_BLOCKS));
    send_beat(CMD_FREE, $urandom, 32'hFFFF_FFFF);
    send_beat(CMD_FREE, $urandom, units_to_bytes(NUM_BLOCKS / 2));
    send_beat(CMD_FREE, $urandom, units_to_bytes(5));
    send_beat(CMD_FREE, $urandom, units_to_bytes(4));
    send_beat(CMD_FREE, $urandom, 0);
    send_beat(CMD_FREE, $urandom, units_to_bytes(1));
    send_beat(CMD_FREE, $urandom, units_to_bytes(2));
    send_beat(CMD_ALLOC, units_to_bytes(NUM_BLOCKS), $urandom);
    send_beat(CMD_ALLOC, 0, $urandom);
    send_beat(CMD_FREE, $urandom, units_to_bytes(3));
    send_beat(CMD_ALLOC, units_to_bytes(NUM_BLOCKS / 2) + 1, $urandom);
    send_beat(CMD_FREE, $urandom, 0);
    send_beat(CMD_FREE, $urandom, 0);
    send_beat(CMD_ALLOC, units_to_bytes(NUM_BLOCKS) + 1, $urandom);
    wait_drained();
    live_blk.delete();

    run_random(150, 1'b1);
    wait_drained();
    write_unit(1);
    run_random(100, 1'b1);
    wait_drained();
    write_unit(0);
    run_random(60, 1'b1);
    wait_drained();
    write_unit(17'd65536);
    run_random(100, 1'b1);
    wait_drained();
    write_unit(17'h1FFFF);
    run_random(80, 1'b1);
    wait_drained();
    write_unit(24);
    run_random(100, 1'b1);
    wait_drained();
    write_unit(UNIT_RESET);
    quiet_tail = 1'b1;
    run_random(100, 1'b0);

    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
